>>> hdl/plrt_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// plrt_pkg
// Shared types and constants for the packet loss recovery tracker: request
// payloads, table entry layout, per-entry evaluation result and sequencer
// state codes.
// ---------------------------------------------------------------------------
package plrt_pkg;

    // table size and register defaults
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int ID_W            = 32;
    localparam int LIFE_W          = 8;
    localparam int EXP_W           = 5;
    localparam logic [LIFE_W-1:0] LIFETIME_RESET = 8'd8;
    localparam logic [EXP_W-1:0]  EXP_MAX        = 5'd31;

    // configuration port layout
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [0:0] REG_ENTRY_LIFETIME = 1'b0;

    // input request kinds
    localparam logic KIND_RECEIVE = 1'b0;
    localparam logic KIND_ERROR   = 1'b1;

    // input request payload
    typedef struct packed {
        logic            kind;
        logic [ID_W-1:0] packet_id;
    } plrt_in_t;

    // result request payload
    typedef struct packed {
        logic             recovered;
        logic             gap_seen;
        logic             resend_valid;
        logic [ID_W-1:0]  resend_id;
        logic [EXP_W-1:0] expired_count;
    } plrt_out_t;

    // one table entry as stored in memory
    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [LIFE_W-1:0] life;
    } plrt_entry_t;

    localparam int ENTRY_W = $bits(plrt_entry_t);

    // verdict of the entry unit on one scanned entry
    typedef struct packed {
        logic              match;
        logic              expire;
        logic              keep;
        logic [LIFE_W-1:0] life;
    } plrt_eval_t;

    // sequencer states, one-hot
    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_FINISH = 3'b100
    } plrt_state_t;

endpackage

>>> hdl/plrt_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// plrt_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ---------------------------------------------------------------------------
module plrt_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/plrt_entry_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// plrt_entry_unit
// Shared evaluation unit: ages one table entry and decides whether it is
// recovered, expired or kept.
// ---------------------------------------------------------------------------
module plrt_entry_unit (
    input  plrt_pkg::plrt_entry_t       entry,
    input  logic [plrt_pkg::ID_W-1:0]   packet_id,
    output plrt_pkg::plrt_eval_t        verdict
);
    import plrt_pkg::*;

    logic [LIFE_W-1:0] life_dec;
    logic              id_eq;

    // lifetime stops at zero
    assign life_dec = (entry.life == '0) ? '0 : entry.life - LIFE_W'(1);
    assign id_eq    = (entry.id == packet_id);

    // recovered beats expired
    always_comb begin
        verdict.match  = id_eq;
        verdict.expire = !id_eq && (life_dec == '0);
        verdict.keep   = !id_eq && (life_dec != '0);
        verdict.life   = life_dec;
    end

endmodule

>>> hdl/packet_loss_recovery_tracker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// packet_loss_recovery_tracker
// Sequence gap tracker with a ring table of missing ids awaiting resend.
// ---------------------------------------------------------------------------
// Input channel (s_valid/s_ready/s_data) takes one request at a time: a
// receive carries a packet id, an error asks for a resend of the expected
// id. Every request gives exactly one result on m_valid/m_ready/m_data.
// An error request passes from idle through the finish state into the
// output register. A receive request scans the pending table once through
// the shared entry unit, one entry a cycle over the single read port of
// the table RAM, then passes through the finish state into the output
// register. s_ready is high only while the sequencer is idle, so the next
// request can be accepted in the cycle in which m_valid rises, at the
// earliest. Results go through an output register, so the next request
// is taken while a result waits; a stalled receiver holds the sequencer
// in its last state until the output register frees up. Reset empties
// the table (count and head cleared, RAM contents left alone), zeroes the
// expected id and loads entry_lifetime with 8. entry_lifetime sits at
// byte address 0 of the APB port and should be written only while the
// block is idle.
// ---------------------------------------------------------------------------
module packet_loss_recovery_tracker #(
    parameter int QUEUE_DEPTH = plrt_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input requests
    input  logic                              s_valid,
    output logic                              s_ready,
    input  plrt_pkg::plrt_in_t                s_data,
    // result requests
    output logic                              m_valid,
    input  logic                              m_ready,
    output plrt_pkg::plrt_out_t               m_data,
    // configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [plrt_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [plrt_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [plrt_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);
    import plrt_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [AW:0]   DEPTH_A = (AW+1)'(QUEUE_DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

    // ring index add, both operands below the depth
    function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] a,
                                               input logic [AW-1:0] b);
        logic [AW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= DEPTH_A) begin
            s = s - DEPTH_A;
        end
        return s[AW-1:0];
    endfunction

    plrt_state_t       state_reg, state_next;
    logic [AW-1:0]     head_reg, head_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [ID_W-1:0]   expected_reg, expected_next;
    logic [LIFE_W-1:0] lifetime_reg, lifetime_next;
    logic [ID_W-1:0]   id_reg, id_next;
    logic [CW-1:0]     rd_idx_reg, rd_idx_next;
    logic [CW-1:0]     wr_idx_reg, wr_idx_next;
    logic              pend_reg, pend_next;
    logic              recov_reg, recov_next;
    logic [EXP_W-1:0]  exp_reg, exp_next;
    plrt_out_t         res_reg, res_next;
    logic              m_valid_reg, m_valid_next;
    plrt_out_t         m_data_reg, m_data_next;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    plrt_entry_t       ram_wdata;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;
    plrt_entry_t       scan_entry;
    plrt_eval_t        verdict;

    logic              cfg_wr;
    logic              s_take;
    logic              out_free;
    logic              scan_done;

    // entry table
    plrt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign scan_entry = plrt_entry_t'(ram_rdata);

    // shared entry evaluation
    plrt_entry_unit u_entry (
        .entry     (scan_entry),
        .packet_id (id_reg),
        .verdict   (verdict)
    );

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2:2] == REG_ENTRY_LIFETIME);
    assign prdata = (paddr[2:2] == REG_ENTRY_LIFETIME)
                  ? {{(APB_DATA_W-LIFE_W){1'b0}}, lifetime_reg} : '0;

    // handshake helpers
    assign s_ready   = (state_reg == ST_IDLE);
    assign s_take    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign scan_done = !pend_reg && (rd_idx_reg == count_reg);

    // read side of the scan
    assign ram_re    = (state_reg == ST_SCAN) && (rd_idx_reg != count_reg);
    assign ram_raddr = ring_add(head_reg, rd_idx_reg[AW-1:0]);

    // sequencer
    always_comb begin
        state_next    = state_reg;
        head_next     = head_reg;
        count_next    = count_reg;
        expected_next = expected_reg;
        lifetime_next = cfg_wr ? pwdata[LIFE_W-1:0] : lifetime_reg;
        id_next       = id_reg;
        rd_idx_next   = rd_idx_reg;
        wr_idx_next   = wr_idx_reg;
        pend_next     = pend_reg;
        recov_next    = recov_reg;
        exp_next      = exp_reg;
        res_next      = res_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_data_next   = m_data_reg;
        ram_we        = 1'b0;
        ram_waddr     = ring_add(head_reg, wr_idx_reg[AW-1:0]);
        ram_wdata.id   = scan_entry.id;
        ram_wdata.life = verdict.life;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_take) begin
                    priority if (s_data.kind == KIND_ERROR) begin
                        // append expected id, dropping the oldest when full
                        ram_we         = 1'b1;
                        ram_wdata.id   = expected_reg;
                        ram_wdata.life = lifetime_reg;
                        if (count_reg == DEPTH_C) begin
                            ram_waddr = head_reg;
                            head_next = ring_add(head_reg, AW'(1));
                        end else begin
                            ram_waddr  = ring_add(head_reg, count_reg[AW-1:0]);
                            count_next = count_reg + CW'(1);
                        end
                        res_next.recovered     = 1'b0;
                        res_next.gap_seen      = 1'b0;
                        res_next.resend_valid  = 1'b1;
                        res_next.resend_id     = expected_reg;
                        res_next.expired_count = '0;
                        expected_next          = expected_reg + ID_W'(1);
                        state_next             = ST_FINISH;
                    end else begin
                        id_next     = s_data.packet_id;
                        rd_idx_next = '0;
                        wr_idx_next = '0;
                        pend_next   = 1'b0;
                        recov_next  = 1'b0;
                        exp_next    = '0;
                        state_next  = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                // evaluate the entry read last cycle and compact survivors
                if (pend_reg) begin
                    if (verdict.match) begin
                        recov_next = 1'b1;
                    end
                    if (verdict.expire && (exp_reg != EXP_MAX)) begin
                        exp_next = exp_reg + EXP_W'(1);
                    end
                    if (verdict.keep) begin
                        ram_we      = 1'b1;
                        wr_idx_next = wr_idx_reg + CW'(1);
                    end
                end
                // issue the next read
                pend_next = ram_re;
                if (ram_re) begin
                    rd_idx_next = rd_idx_reg + CW'(1);
                end
                if (scan_done) begin
                    count_next             = wr_idx_reg;
                    res_next.recovered     = recov_reg;
                    res_next.gap_seen      = !recov_reg && (id_reg != expected_reg);
                    res_next.resend_valid  = 1'b0;
                    res_next.resend_id     = '0;
                    res_next.expired_count = exp_reg;
                    if (!recov_reg) begin
                        expected_next = id_reg + ID_W'(1);
                    end
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                // hand the result to the output register once it is free
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            head_reg     <= '0;
            count_reg    <= '0;
            expected_reg <= '0;
            lifetime_reg <= LIFETIME_RESET;
            pend_reg     <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            count_reg    <= count_next;
            expected_reg <= expected_next;
            lifetime_reg <= lifetime_next;
            pend_reg     <= pend_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        id_reg     <= id_next;
        rd_idx_reg <= rd_idx_next;
        wr_idx_reg <= wr_idx_next;
        recov_reg  <= recov_next;
        exp_reg    <= exp_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

>>> hdl/plrt_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// plrt_checker
// Port-level checks for the packet loss recovery tracker, bound to the
// top level.
// ---------------------------------------------------------------------------
module plrt_checker (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_valid,
    input logic                  s_ready,
    input logic                  m_valid,
    input logic                  m_ready,
    input plrt_pkg::plrt_out_t   m_data
);
    import plrt_pkg::*;

    // no result right after reset
    property p_reset_quiet;
        @(posedge aclk) !aresetn |=> !m_valid;
    endproperty
    a_reset_quiet: assert property (p_reset_quiet)
        else $error("result valid right after reset");

    // one request in flight: busy right after an accept
    property p_busy_after_accept;
        @(posedge aclk) disable iff (!aresetn)
            (s_valid && s_ready) |=> !s_ready;
    endproperty
    a_busy_after_accept: assert property (p_busy_after_accept)
        else $error("input ready right after an accepted request");

    // error results carry only the resend request
    property p_error_fields;
        @(posedge aclk) disable iff (!aresetn)
            (m_valid && m_data.resend_valid) |->
                (!m_data.recovered && !m_data.gap_seen && (m_data.expired_count == '0));
    endproperty
    a_error_fields: assert property (p_error_fields)
        else $error("error result with receive fields set");

    // receive results carry no resend id, and no gap when recovered
    property p_receive_fields;
        @(posedge aclk) disable iff (!aresetn)
            (m_valid && !m_data.resend_valid) |->
                ((m_data.resend_id == '0) && !(m_data.recovered && m_data.gap_seen));
    endproperty
    a_receive_fields: assert property (p_receive_fields)
        else $error("receive result with inconsistent fields");

    // stalled result holds
    property p_out_hold;
        @(posedge aclk) disable iff (!aresetn)
            (m_valid && !m_ready) |=> (m_valid && $stable(m_data));
    endproperty
    a_out_hold: assert property (p_out_hold)
        else $error("stalled result changed or dropped");

endmodule

bind packet_loss_recovery_tracker plrt_checker u_plrt_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

>>> dv/tb_packet_loss_recovery_tracker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_packet_loss_recovery_tracker
// Self-checking bench for the packet loss recovery tracker. A directed
// sequence hits recovery, gaps, id wrap, duplicate table entries and zero
// lifetime. Random traffic then runs under several entry_lifetime settings:
// in-order runs, error bursts that overflow the table, recoveries of
// requested ids, skips and random ids. A shadow of the tracker predicts
// every result, and results are compared field by field in order.
// ---------------------------------------------------------------------------
module tb_packet_loss_recovery_tracker;
    import plrt_pkg::*;

    localparam int DEPTH        = QUEUE_DEPTH_DEF;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE       = 40;
    localparam int STALL_AT     = 150;
    localparam int STALL_CYCLES = 200;
    localparam logic [APB_ADDR_W-1:0] ADDR_LIFETIME = APB_ADDR_W'(4 * REG_ENTRY_LIFETIME);
    // index 1, no register there
    localparam logic [APB_ADDR_W-1:0] ADDR_UNUSED   = APB_ADDR_W'(4);

    logic                  aclk    = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    plrt_in_t              s_data  = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    plrt_out_t             m_data;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [APB_ADDR_W-1:0] paddr   = '0;
    logic [APB_DATA_W-1:0] pwdata  = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    packet_loss_recovery_tracker #(
        .QUEUE_DEPTH (DEPTH)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // shadow tracker state
    logic [ID_W-1:0]   exp_id       = '0;
    logic [ID_W-1:0]   tbl_id[DEPTH];
    logic [LIFE_W-1:0] tbl_life[DEPTH];
    int                tbl_cnt      = 0;
    logic [LIFE_W-1:0] cfg_lifetime = LIFETIME_RESET;

    plrt_in_t          request_q[$];
    plrt_out_t         outcome_q[$];
    int                n_fail       = 0;
    int                n_accepted   = 0;
    int                n_cycles     = 0;
    logic              calm         = 1'b0;

    // stimulus-side guess of the tracker, only used to shape traffic
    logic [ID_W-1:0]   gen_exp      = '0;
    logic [ID_W-1:0]   missing_q[$];

    // predicted result of one request, advances the shadow state
    function automatic plrt_out_t expected_outcome(plrt_in_t req);
        plrt_out_t         res;
        int                wr;
        logic [LIFE_W-1:0] life;
        res = '0;
        if (req.kind == KIND_ERROR) begin
            res.resend_valid = 1'b1;
            res.resend_id    = exp_id;
            // full table drops its oldest entry
            if (tbl_cnt >= DEPTH) begin
                for (int i = 0; i + 1 < DEPTH; i++) begin
                    tbl_id[i]   = tbl_id[i + 1];
                    tbl_life[i] = tbl_life[i + 1];
                end
                tbl_cnt = DEPTH - 1;
            end
            tbl_id[tbl_cnt]   = exp_id;
            tbl_life[tbl_cnt] = cfg_lifetime;
            tbl_cnt++;
            exp_id++;
        end else begin
            wr = 0;
            for (int rd = 0; rd < tbl_cnt; rd++) begin
                life = tbl_life[rd];
                if (life != 0) begin
                    life--;
                end
                if (tbl_id[rd] == req.packet_id) begin
                    res.recovered = 1'b1;
                end else if (life == 0) begin
                    if (res.expired_count != EXP_MAX) begin
                        res.expired_count++;
                    end
                end else begin
                    tbl_id[wr]   = tbl_id[rd];
                    tbl_life[wr] = life;
                    wr++;
                end
            end
            tbl_cnt = wr;
            if (!res.recovered) begin
                res.gap_seen = (req.packet_id != exp_id);
                exp_id       = req.packet_id + 1;
            end
        end
        return res;
    endfunction

    // clock
    initial begin
        forever #4 aclk = ~aclk;
    end

    // run-away guard
    always @(posedge aclk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles == CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // request sender
    int send_idle = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid   <= 1'b0;
            send_idle <= 0;
        end else begin
            if (s_valid && s_ready) begin
                outcome_q.push_back(expected_outcome(s_data));
                n_accepted <= n_accepted + 1;
            end
            if (s_valid && !s_ready) begin
                // hold the offered request
            end else if (send_idle > 0) begin
                s_valid   <= 1'b0;
                send_idle <= send_idle - 1;
            end else if (request_q.size() == 0) begin
                s_valid <= 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                s_valid   <= 1'b0;
                send_idle <= $urandom_range(0, 2);
            end else begin
                s_valid <= 1'b1;
                s_data  <= request_q.pop_front();
            end
        end
    end

    // result receiver, with one long hold-off to back the block up
    int   ready_idle = 0;
    int   hold_left  = 0;
    logic hold_done  = 1'b0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!hold_done && n_accepted >= STALL_AT) begin
            m_ready   <= 1'b0;
            hold_left <= STALL_CYCLES;
            hold_done <= 1'b1;
        end else if (ready_idle > 0) begin
            m_ready    <= 1'b0;
            ready_idle <= ready_idle - 1;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
            m_ready    <= 1'b0;
            ready_idle <= $urandom_range(0, 2);
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            n_fail++;
        end
    endtask

    // result checker
    always @(posedge aclk) begin
        plrt_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (outcome_q.size() == 0) begin
                $error("result with no request outstanding: 0x%0h", m_data);
                n_fail++;
            end else begin
                want = outcome_q.pop_front();
                check_field("recovered", 32'(want.recovered), 32'(m_data.recovered));
                check_field("gap_seen", 32'(want.gap_seen), 32'(m_data.gap_seen));
                check_field("resend_valid", 32'(want.resend_valid),
                            32'(m_data.resend_valid));
                check_field("resend_id", want.resend_id, m_data.resend_id);
                check_field("expired_count", 32'(want.expired_count),
                            32'(m_data.expired_count));
            end
        end
    end

    // configuration port access
    task automatic cfg_write(input logic [APB_ADDR_W-1:0] addr, input logic [31:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_LIFETIME) begin
            cfg_lifetime = value[LIFE_W-1:0];
        end
    endtask

    task automatic check_lifetime_readback();
        logic [31:0] got;
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_LIFETIME;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        check_field("entry_lifetime", 32'(cfg_lifetime), 32'(got[LIFE_W-1:0]));
    endtask

    // stimulus helpers
    task automatic queue_request(input logic kind, input logic [ID_W-1:0] id);
        plrt_in_t req;
        req.kind      = kind;
        req.packet_id = id;
        request_q.push_back(req);
    endtask

    task automatic push_rx(input logic [ID_W-1:0] id);
        queue_request(KIND_RECEIVE, id);
        gen_exp = id + 1;
    endtask

    task automatic push_err();
        missing_q.push_back(gen_exp);
        if (missing_q.size() > 24) begin
            void'(missing_q.pop_front());
        end
        gen_exp++;
        // id field is ignored on errors, fill it anyway
        queue_request(KIND_ERROR, $urandom);
    endtask

    // random traffic, mostly ordered streams with losses and recoveries
    task automatic gen_traffic(input int count);
        int left;
        int r;
        int len;
        int k;
        left = count;
        while (left > 0) begin
            r = $urandom_range(0, 99);
            if (r < 15) begin
                // error burst, now and then long enough to overflow the table
                len = ($urandom_range(0, 19) == 0) ? $urandom_range(16, 20)
                                                   : $urandom_range(1, 3);
                repeat (len) push_err();
                left -= len;
            end else if (r < 40 && missing_q.size() != 0) begin
                // resent packet arrives
                k = $urandom_range(0, missing_q.size() - 1);
                queue_request(KIND_RECEIVE, missing_q[k]);
                missing_q.delete(k);
                left--;
            end else if (r < 85) begin
                len = $urandom_range(1, 6);
                repeat (len) push_rx(gen_exp);
                left -= len;
            end else if (r < 92) begin
                push_rx(gen_exp + $urandom_range(1, 5));
                left--;
            end else if (r < 95) begin
                // close to the id wrap
                push_rx(32'hFFFF_FFFF - $urandom_range(0, 3));
                left--;
            end else begin
                push_rx($urandom);
                left--;
            end
        end
    endtask

    // wait until all requests are in and all results are back
    task automatic drain();
        @(negedge aclk);
        while (request_q.size() != 0 || s_valid || outcome_q.size() != 0) begin
            @(negedge aclk);
        end
        repeat (SETTLE) @(posedge aclk);
    endtask

    // main sequence
    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        check_lifetime_readback();

        // recovery, repeated id, id wrap, skip then late recovery
        push_err();
        push_rx(32'd0);
        push_rx(32'd0);
        push_rx(32'd1);
        push_rx(32'hFFFF_FFFF);
        push_rx(32'd0);
        push_err();
        push_err();
        push_rx(32'd5);
        push_rx(32'd2);
        // same id requested twice, one receive clears both
        push_err();
        push_rx(32'd5);
        push_err();
        push_rx(32'd6);
        // resend of the last id before the wrap
        push_rx(32'hFFFF_FFFE);
        push_err();
        push_rx(32'd0);
        drain();

        // zero lifetime: expire at the next receive unless matched
        cfg_write(ADDR_LIFETIME, 32'd0);
        push_err();
        push_err();
        push_rx(32'd100);
        push_err();
        push_rx(32'd101);
        drain();

        // write to an unmapped address must leave the register alone
        cfg_write(ADDR_UNUSED, 32'd77);
        check_lifetime_readback();

        cfg_write(ADDR_LIFETIME, 32'd255);
        check_lifetime_readback();
        gen_traffic(200);
        drain();

        cfg_write(ADDR_LIFETIME, 32'd1);
        gen_traffic(150);
        drain();

        cfg_write(ADDR_LIFETIME, $urandom_range(2, 254));
        check_lifetime_readback();
        gen_traffic(200);
        drain();

        cfg_write(ADDR_LIFETIME, 32'd3);
        gen_traffic(150);
        drain();

        // back-to-back tail, no idling on either side
        cfg_write(ADDR_LIFETIME, 32'd8);
        calm = 1'b1;
        gen_traffic(200);
        drain();

        if (n_fail == 0 && outcome_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

>>> filelist.f
hdl/plrt_pkg.sv
hdl/plrt_ram.sv
hdl/plrt_entry_unit.sv
hdl/packet_loss_recovery_tracker.sv
hdl/plrt_checker.sv
dv/tb_packet_loss_recovery_tracker.sv
